// ===== rtl/core/rtos_sched_pkg.sv =====
// Package for the priority/delay task scheduler: request codes, task states,
// transfer structs. No dependencies.
package rtos_sched_pkg;

  typedef enum logic [2:0] {
    REQ_SCHEDULE = 3'd0,
    REQ_READY    = 3'd1,
    REQ_DELAY    = 3'd2,
    REQ_SUSPEND  = 3'd3,
    REQ_RESUME   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_UNLISTED  = 3'd0,
    ST_READY     = 3'd1,
    ST_WAITING   = 3'd2,
    ST_SUSPENDED = 3'd3,
    ST_RUNNING   = 3'd4
  } task_state_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_QUEUED   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_WAKE,
    FSM_WAKE_APPLY,
    FSM_PICK,
    FSM_PICK_APPLY,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  task_id;
    logic [3:0]  task_priority;
    logic [31:0] wake_time;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       running_valid;
    logic [1:0] status;
  } rsp_t;

endpackage

// ===== rtl/core/rtos_sched_cell.sv =====
// One task-table cell: holds state, priority, wake time and arrival rank of a
// task, and takes part in the best-candidate chain. Uses rtos_sched_pkg.
module rtos_sched_cell #(
  parameter int PRIO_BITS = 4,
  parameter int TIME_BITS = 32,
  parameter int ORD_BITS  = 5,
  parameter int IDX_BITS  = 4,
  parameter logic [IDX_BITS-1:0] MY_IDX = '0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // control, common to all cells
  input  logic                                wr_i,
  input  rtos_sched_pkg::task_state_e         wr_state_i,
  input  logic                                wr_prio_en_i,
  input  logic [PRIO_BITS-1:0]                wr_prio_i,
  input  logic                                wr_wake_en_i,
  input  logic [TIME_BITS-1:0]                wr_wake_i,
  input  logic                                wr_order_en_i,
  input  logic [ORD_BITS-1:0]                 wr_order_i,
  input  logic                                unq_i,
  input  logic [ORD_BITS-1:0]                 unq_rank_i,
  input  logic [TIME_BITS-1:0]                now_i,
  input  logic                                mode_wake_i,
  // chain from the previous cell
  input  logic                                c_valid_i,
  input  logic [IDX_BITS-1:0]                 c_idx_i,
  input  logic [TIME_BITS-1:0]                c_key_i,
  input  logic [ORD_BITS-1:0]                 c_ord_i,
  output logic                                c_valid_o,
  output logic [IDX_BITS-1:0]                 c_idx_o,
  output logic [TIME_BITS-1:0]                c_key_o,
  output logic [ORD_BITS-1:0]                 c_ord_o,
  output rtos_sched_pkg::task_state_e         state_o,
  output logic [ORD_BITS-1:0]                 order_o
);
  import rtos_sched_pkg::*;

  task_state_e          state_q;
  logic [PRIO_BITS-1:0] prio_q;
  logic [TIME_BITS-1:0] wake_q;
  logic [ORD_BITS-1:0]  order_q;
  logic                 queued, cand, better;
  logic [TIME_BITS-1:0] my_key;

  assign queued = (state_q == ST_READY) || (state_q == ST_WAITING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_UNLISTED;
      prio_q  <= '0;
      wake_q  <= '0;
      order_q <= '0;
    end else begin
      if (unq_i && queued && !wr_i && order_q > unq_rank_i) begin
        order_q <= order_q - 1'b1;
      end
      if (wr_i) begin
        state_q <= wr_state_i;
        if (wr_prio_en_i) prio_q <= wr_prio_i;
        if (wr_wake_en_i) wake_q <= wr_wake_i;
        if (wr_order_en_i) order_q <= wr_order_i;
      end
    end
  end

  // wake mode: smallest wake, then rank; pick mode: highest prio, then rank
  always_comb begin
    if (mode_wake_i) begin
      cand   = (state_q == ST_WAITING) && (wake_q <= now_i);
      my_key = wake_q;
      better = (my_key < c_key_i) || ((my_key == c_key_i) && (order_q < c_ord_i));
    end else begin
      cand   = (state_q == ST_READY);
      my_key = TIME_BITS'(prio_q);
      better = (my_key > c_key_i) || ((my_key == c_key_i) && (order_q < c_ord_i));
    end
  end

  always_comb begin
    if (cand && (!c_valid_i || better)) begin
      c_valid_o = 1'b1;
      c_idx_o   = MY_IDX;
      c_key_o   = my_key;
      c_ord_o   = order_q;
    end else begin
      c_valid_o = c_valid_i;
      c_idx_o   = c_idx_i;
      c_key_o   = c_key_i;
      c_ord_o   = c_ord_i;
    end
  end

  assign state_o = state_q;
  assign order_o = order_q;

endmodule

// ===== rtl/core/rtos_sched_chain.sv =====
// Row of task cells with a registered best-candidate hand-off every four
// cells. Uses rtos_sched_pkg and rtos_sched_cell.
module rtos_sched_chain #(
  parameter int NUM_TASKS = 16,
  parameter int PRIO_BITS = 4,
  parameter int TIME_BITS = 32,
  parameter int ORD_BITS  = 5,
  parameter int IDX_BITS  = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_i,
  input  logic [IDX_BITS-1:0]         wr_idx_i,
  input  rtos_sched_pkg::task_state_e wr_state_i,
  input  logic                        wr_prio_en_i,
  input  logic [PRIO_BITS-1:0]        wr_prio_i,
  input  logic                        wr_wake_en_i,
  input  logic [TIME_BITS-1:0]        wr_wake_i,
  input  logic                        wr_order_en_i,
  input  logic [ORD_BITS-1:0]         wr_order_i,
  input  logic                        unq_i,
  input  logic [ORD_BITS-1:0]         unq_rank_i,
  input  logic [TIME_BITS-1:0]        now_i,
  input  logic                        mode_wake_i,
  input  logic                        scan_start_i,
  output logic                        best_valid_o,
  output logic [IDX_BITS-1:0]         best_idx_o,
  output rtos_sched_pkg::task_state_e state_o [NUM_TASKS],
  output logic [ORD_BITS-1:0]         order_o [NUM_TASKS]
);
  import rtos_sched_pkg::*;

  localparam int Seg  = 4;
  localparam int Nseg = (NUM_TASKS + Seg - 1) / Seg;

  logic                 v [1:NUM_TASKS];
  logic [IDX_BITS-1:0]  ix [1:NUM_TASKS];
  logic [TIME_BITS-1:0] ky [1:NUM_TASKS];
  logic [ORD_BITS-1:0]  od [1:NUM_TASKS];

  logic                 rv_q [Nseg];
  logic [IDX_BITS-1:0]  ri_q [Nseg];
  logic [TIME_BITS-1:0] rk_q [Nseg];
  logic [ORD_BITS-1:0]  ro_q [Nseg];

  genvar g;
  generate
    for (g = 0; g < NUM_TASKS; g++) begin : g_cell
      logic                 vi;
      logic [IDX_BITS-1:0]  ii;
      logic [TIME_BITS-1:0] ki;
      logic [ORD_BITS-1:0]  oi;
      if (g == 0) begin : g_head
        assign vi = 1'b0; assign ii = '0; assign ki = '0; assign oi = '0;
      end else if ((g % Seg) == 0) begin : g_reg
        assign vi = rv_q[g/Seg-1]; assign ii = ri_q[g/Seg-1];
        assign ki = rk_q[g/Seg-1]; assign oi = ro_q[g/Seg-1];
      end else begin : g_thru
        assign vi = v[g]; assign ii = ix[g]; assign ki = ky[g]; assign oi = od[g];
      end
      rtos_sched_cell #(
        .PRIO_BITS(PRIO_BITS), .TIME_BITS(TIME_BITS), .ORD_BITS(ORD_BITS),
        .IDX_BITS(IDX_BITS), .MY_IDX(IDX_BITS'(g))
      ) u_cell (
        .clk_i, .rst_ni,
        .wr_i(wr_i && (wr_idx_i == IDX_BITS'(g))),
        .wr_state_i, .wr_prio_en_i, .wr_prio_i, .wr_wake_en_i, .wr_wake_i,
        .wr_order_en_i, .wr_order_i, .unq_i, .unq_rank_i, .now_i, .mode_wake_i,
        .c_valid_i(vi), .c_idx_i(ii), .c_key_i(ki), .c_ord_i(oi),
        .c_valid_o(v[g+1]), .c_idx_o(ix[g+1]), .c_key_o(ky[g+1]), .c_ord_o(od[g+1]),
        .state_o(state_o[g]), .order_o(order_o[g])
      );
    end
    for (g = 0; g < Nseg; g++) begin : g_seg
      localparam int Last = ((g + 1) * Seg < NUM_TASKS) ? (g + 1) * Seg : NUM_TASKS;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          rv_q[g] <= 1'b0;
        end else if (scan_start_i) begin
          rv_q[g] <= 1'b0;
        end else begin
          rv_q[g] <= v[Last];
        end
      end
      always_ff @(posedge clk_i) begin
        ri_q[g] <= ix[Last];
        rk_q[g] <= ky[Last];
        ro_q[g] <= od[Last];
      end
    end
  endgenerate

  assign best_valid_o = rv_q[Nseg-1];
  assign best_idx_o   = ri_q[Nseg-1];

endmodule

// ===== rtl/core/rtos_priority_delay_scheduler.sv =====
// Top level of the priority/delay task scheduler: request decode, sequencer
// and the task cell chain. Uses rtos_sched_pkg and rtos_sched_chain.
//
// Channel   Dir  Handshake             Payload
// request   in   start & !busy         req_i   (req_t)
// result    out  done_o, one cycle     rsp_o   (rsp_t)
//
// A plain request passes through the done state; done_o is registered from it.
// Schedule, and suspend of the running task, first run one wake scan per
// woken task and a last wake scan that finds none, then a pick scan; each
// chain scan settles through one register per four cells.
// Reset clears all task state; no clearing pass. busy stalls requests and
// drops in the done_o cycle; the receiver cannot stall results.
module rtos_priority_delay_scheduler #(
  parameter int NUM_TASKS = 16,
  parameter int PRIO_BITS = 4,
  parameter int TIME_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  rtos_sched_pkg::req_t   req_i,
  output logic                   done_o,
  output rtos_sched_pkg::rsp_t   rsp_o
);
  import rtos_sched_pkg::*;

  localparam int IdxBits = (NUM_TASKS <= 2) ? 1 : $clog2(NUM_TASKS);
  localparam int OrdBits = $clog2(NUM_TASKS + 1);
  localparam int Nseg    = (NUM_TASKS + 3) / 4;
  localparam int CntBits = $clog2(Nseg + 1);

  fsm_e                  st_q, st_d;
  logic [IdxBits-1:0]    run_q;
  logic                  run_v_q;
  logic [OrdBits-1:0]    cnt_q;
  logic [1:0]            status_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [CntBits-1:0]    wait_q;
  logic                  done_q;

  logic                  wr;
  logic [IdxBits-1:0]    wr_idx;
  task_state_e           wr_state;
  logic                  wr_prio_en, wr_wake_en, wr_order_en, unq;
  logic [OrdBits-1:0]    wr_order, unq_rank;
  logic                  mode_wake, scan_start;
  logic                  best_v;
  logic [IdxBits-1:0]    best_i;
  task_state_e           states [NUM_TASKS];
  logic [OrdBits-1:0]    orders [NUM_TASKS];

  logic                  accept;
  logic                  id_ok;
  logic [IdxBits-1:0]    tid;
  task_state_e           tst;
  logic                  do_sched;

  assign accept = start && !busy;
  assign busy   = (st_q != FSM_IDLE);
  assign id_ok  = ({28'd0, req_i.task_id} < 32'(NUM_TASKS));
  assign tid    = IdxBits'(req_i.task_id);
  assign tst    = states[tid];

  always_comb begin
    do_sched = 1'b0;
    if (accept) begin
      if (req_i.req_type == REQ_SCHEDULE) do_sched = 1'b1;
      if (req_i.req_type == REQ_SUSPEND && id_ok && tst == ST_RUNNING) do_sched = 1'b1;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      FSM_IDLE:       if (accept) st_d = do_sched ? FSM_WAKE : FSM_DONE;
      FSM_WAKE:       if (wait_q == CntBits'(Nseg)) st_d = best_v ? FSM_WAKE_APPLY : FSM_PICK;
      FSM_WAKE_APPLY: st_d = FSM_WAKE;
      FSM_PICK:       if (wait_q == CntBits'(Nseg)) st_d = FSM_PICK_APPLY;
      FSM_PICK_APPLY: st_d = FSM_DONE;
      FSM_DONE:       st_d = FSM_IDLE;
      default:        st_d = FSM_IDLE;
    endcase
  end

  // cell write controls
  always_comb begin
    wr = 1'b0; wr_idx = tid; wr_state = ST_UNLISTED;
    wr_prio_en = 1'b0; wr_wake_en = 1'b0; wr_order_en = 1'b0;
    wr_order = cnt_q; unq = 1'b0; unq_rank = orders[tid];
    mode_wake = (st_q == FSM_WAKE);
    scan_start = 1'b0;
    case (st_q)
      FSM_IDLE: begin
        scan_start = 1'b1;
        if (accept && id_ok) begin
          case (req_i.req_type)
            REQ_READY, REQ_DELAY: begin
              if (tst == ST_UNLISTED || tst == ST_RUNNING) begin
                wr = 1'b1; wr_order_en = 1'b1;
                if (req_i.req_type == REQ_READY) begin
                  wr_state = ST_READY; wr_prio_en = 1'b1;
                end else begin
                  wr_state = ST_WAITING; wr_wake_en = 1'b1;
                end
              end
            end
            REQ_SUSPEND: begin
              if (tst == ST_RUNNING) begin
                wr = 1'b1; wr_state = ST_SUSPENDED;
              end else if (tst == ST_READY || tst == ST_WAITING) begin
                wr = 1'b1; wr_state = ST_SUSPENDED; unq = 1'b1;
              end
            end
            REQ_RESUME: begin
              if (tst == ST_SUSPENDED) begin
                wr = 1'b1; wr_state = ST_READY; wr_order_en = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_WAKE_APPLY: begin
        // dequeue and re-file as newest ready; rank becomes cnt-1 after shift
        wr = 1'b1; wr_idx = best_i; wr_state = ST_READY;
        wr_order_en = 1'b1; wr_order = cnt_q - 1'b1;
        unq = 1'b1; unq_rank = orders[best_i];
        scan_start = 1'b1;
      end
      FSM_PICK_APPLY: begin
        if (best_v) begin
          wr = 1'b1; wr_idx = best_i; wr_state = ST_RUNNING;
          unq = 1'b1; unq_rank = orders[best_i];
        end
      end
      FSM_WAKE: begin
        if (wait_q == CntBits'(Nseg) && !best_v && run_v_q) begin
          wr = 1'b1; wr_idx = run_q; wr_state = ST_READY;
          wr_order_en = 1'b1;
        end
        if (wait_q == CntBits'(Nseg)) scan_start = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= FSM_IDLE;
      run_q    <= '0;
      run_v_q  <= 1'b0;
      cnt_q    <= '0;
      status_q <= STAT_OK;
      wait_q   <= '0;
      done_q   <= 1'b0;
      now_q    <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == FSM_DONE);
      if (st_d != st_q || st_q == FSM_WAKE_APPLY) wait_q <= '0;
      else if (wait_q != CntBits'(Nseg)) wait_q <= wait_q + 1'b1;
      if (st_q == FSM_IDLE && accept) begin
        now_q    <= TIME_BITS'(req_i.now);
        status_q <= STAT_OK;
        if (req_i.req_type != REQ_SCHEDULE && req_i.req_type <= REQ_RESUME) begin
          if (!id_ok) begin
            status_q <= STAT_NOTFOUND;
          end else begin
            case (req_i.req_type)
              REQ_READY, REQ_DELAY: begin
                if (tst == ST_UNLISTED || tst == ST_RUNNING) begin
                  cnt_q <= cnt_q + 1'b1;
                  if (tst == ST_RUNNING) run_v_q <= 1'b0;
                end else begin
                  status_q <= STAT_QUEUED;
                end
              end
              REQ_SUSPEND: begin
                if (tst == ST_RUNNING) run_v_q <= 1'b0;
                else if (tst == ST_READY || tst == ST_WAITING) cnt_q <= cnt_q - 1'b1;
                else status_q <= STAT_NOTFOUND;
              end
              REQ_RESUME: begin
                if (tst == ST_SUSPENDED) cnt_q <= cnt_q + 1'b1;
                else status_q <= STAT_NOTFOUND;
              end
              default: ;
            endcase
          end
        end
      end
      if (st_q == FSM_WAKE && wait_q == CntBits'(Nseg) && !best_v && run_v_q) begin
        cnt_q   <= cnt_q + 1'b1;
        run_v_q <= 1'b0;
      end
      if (st_q == FSM_PICK_APPLY && best_v) begin
        cnt_q   <= cnt_q - 1'b1;
        run_q   <= best_i;
        run_v_q <= 1'b1;
      end
    end
  end

  rtos_sched_chain #(
    .NUM_TASKS(NUM_TASKS), .PRIO_BITS(PRIO_BITS), .TIME_BITS(TIME_BITS),
    .ORD_BITS(OrdBits), .IDX_BITS(IdxBits)
  ) u_chain (
    .clk_i, .rst_ni,
    .wr_i(wr), .wr_idx_i(wr_idx), .wr_state_i(wr_state),
    .wr_prio_en_i(wr_prio_en), .wr_prio_i(PRIO_BITS'(req_i.task_priority)),
    .wr_wake_en_i(wr_wake_en), .wr_wake_i(TIME_BITS'(req_i.wake_time)),
    .wr_order_en_i(wr_order_en), .wr_order_i(wr_order),
    .unq_i(unq), .unq_rank_i(unq_rank), .now_i(now_q),
    .mode_wake_i(mode_wake), .scan_start_i(scan_start),
    .best_valid_o(best_v), .best_idx_o(best_i),
    .state_o(states), .order_o(orders)
  );

  assign done_o              = done_q;
  assign rsp_o.running_task  = run_v_q ? 4'(run_q) : 4'd0;
  assign rsp_o.running_valid = run_v_q;
  assign rsp_o.status        = status_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> st_q == FSM_IDLE) else $error("done outside idle");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held for more than one cycle");
  a_run_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && run_v_q) |-> states[run_q] == ST_RUNNING)
    else $error("running task not in running state");

endmodule

// ===== bench/rtos_priority_delay_scheduler_tb.sv =====
// Self-checking bench for rtos_priority_delay_scheduler: directed and random
// requests, results predicted by an in-bench task table model.
// Depends on rtos_sched_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module rtos_priority_delay_scheduler_tb;
  import rtos_sched_pkg::*;

  localparam int NTASK = 16;
  localparam int IDLE_LIMIT = 5000;

  logic clk_i, rst_ni, start, busy, done_o;
  req_t req_i;
  rsp_t rsp_o;

  rtos_priority_delay_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  // scheduler table mirror
  task_state_e tstate[NTASK];
  logic [3:0]  tprio[NTASK];
  logic [31:0] twake[NTASK];
  logic [7:0]  torder[NTASK];
  logic [7:0]  nqueued;
  int          run_slot;

  req_t pending_q[$];
  rsp_t expect_q[$];
  int   n_sent, n_checked, n_errors, n_sched, n_busy_rsp;
  int   burst_left, gap_left, idle_cycles;
  bit   hold_drain, drained_once;
  logic [31:0] tick;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit queued(int i);
    return tstate[i] == ST_READY || tstate[i] == ST_WAITING;
  endfunction

  function automatic void drop_rank(int i);
    for (int j = 0; j < NTASK; j++)
      if (j != i && queued(j) && torder[j] > torder[i]) torder[j]--;
    if (nqueued > 0) nqueued--;
    tstate[i] = ST_UNLISTED;
  endfunction

  function automatic void file_task(int i, task_state_e st);
    tstate[i] = st;
    torder[i] = nqueued;
    nqueued++;
  endfunction

  function automatic void pick_next(logic [31:0] now);
    int best, head;
    for (int n = 0; n < NTASK; n++) begin
      best = NTASK;
      for (int j = 0; j < NTASK; j++) begin
        if (tstate[j] != ST_WAITING || twake[j] > now) continue;
        if (best == NTASK || twake[j] < twake[best] ||
            (twake[j] == twake[best] && torder[j] < torder[best])) best = j;
      end
      if (best == NTASK) break;
      drop_rank(best);
      file_task(best, ST_READY);
    end
    if (run_slot < NTASK) begin
      file_task(run_slot, ST_READY);
      run_slot = NTASK;
    end
    head = NTASK;
    for (int j = 0; j < NTASK; j++) begin
      if (tstate[j] != ST_READY) continue;
      if (head == NTASK || tprio[j] > tprio[head] ||
          (tprio[j] == tprio[head] && torder[j] < torder[head])) head = j;
    end
    if (head < NTASK) begin
      drop_rank(head);
      tstate[head] = ST_RUNNING;
      run_slot = head;
    end
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    status_e stat;
    int t;
    stat = STAT_OK;
    t = r.task_id;
    case (r.req_type)
      REQ_SCHEDULE: pick_next(r.now);
      REQ_READY, REQ_DELAY: begin
        if (tstate[t] == ST_UNLISTED || tstate[t] == ST_RUNNING) begin
          if (tstate[t] == ST_RUNNING) run_slot = NTASK;
          if (r.req_type == REQ_READY) begin
            tprio[t] = r.task_priority;
            file_task(t, ST_READY);
          end else begin
            twake[t] = r.wake_time;
            file_task(t, ST_WAITING);
          end
        end else stat = STAT_QUEUED;
      end
      REQ_SUSPEND: begin
        if (tstate[t] == ST_RUNNING) begin
          tstate[t] = ST_SUSPENDED;
          run_slot = NTASK;
          pick_next(r.now);
        end else if (queued(t)) begin
          drop_rank(t);
          tstate[t] = ST_SUSPENDED;
        end else stat = STAT_NOTFOUND;
      end
      REQ_RESUME: begin
        if (tstate[t] == ST_SUSPENDED) file_task(t, ST_READY);
        else stat = STAT_NOTFOUND;
      end
      default: ;
    endcase
    o.running_valid = run_slot < NTASK;
    o.running_task = o.running_valid ? 4'(run_slot) : 4'd0;
    o.status = stat;
    return o;
  endfunction

  function automatic req_t mk(logic [2:0] op, int id, int prio,
                              logic [31:0] wake, logic [31:0] now);
    req_t r;
    r.req_type = op;
    r.task_id = 4'(id);
    r.task_priority = 4'(prio);
    r.wake_time = wake;
    r.now = now;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.task_id = 4'($urandom_range(0, 15));
    r.task_priority = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 1) * 15)
                                                 : 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) begin
      r.wake_time = $urandom;
      r.now = $urandom;
    end else begin
      r.wake_time = tick + $urandom_range(0, 40);
      r.now = tick;
    end
    if (sel < 30) begin
      r.req_type = REQ_SCHEDULE;
      tick = tick + $urandom_range(0, 12);
    end else if (sel < 55) r.req_type = REQ_READY;
    else if (sel < 75) r.req_type = REQ_DELAY;
    else if (sel < 88) r.req_type = REQ_SUSPEND;
    else if (sel < 97) r.req_type = REQ_RESUME;
    else r.req_type = 3'($urandom_range(5, 7));
    return r;
  endfunction

  // driver: bursts of requests with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (hold_drain && !drained_once) begin
      start <= 1'b0;
      if (expect_q.size() == 0) drained_once = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_q.size() > 0) begin
      start <= 1'b1;
      req_i <= pending_q[0];
    end else begin
      start <= 1'b0;
    end
  end

  // monitor, checker and predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (done_o) begin
        idle_cycles = 0;
        if (expect_q.size() == 0) begin
          $display("%0t: result with none expected: %p", $time, rsp_o);
          n_errors++;
        end else begin
          if (rsp_o !== expect_q[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time, expect_q[0], rsp_o);
            n_errors++;
          end
          if (rsp_o.running_valid) n_busy_rsp++;
          void'(expect_q.pop_front());
          n_checked++;
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        if (pending_q[0].req_type == REQ_SCHEDULE) n_sched++;
        expect_q.push_back(serve_request(pending_q[0]));
        void'(pending_q.pop_front());
        n_sent++;
        if (n_sent == 700) hold_drain = 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("rtos_priority_delay_scheduler test failed");
        $finish;
      end
    end
  end

  initial begin
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    n_sent = 0; n_checked = 0; n_errors = 0; n_sched = 0; n_busy_rsp = 0;
    burst_left = 0; gap_left = 0; idle_cycles = 0;
    hold_drain = 1'b0; drained_once = 1'b0;
    tick = 32'd100;
    for (int i = 0; i < NTASK; i++) begin
      tstate[i] = ST_UNLISTED;
      tprio[i] = '0; twake[i] = '0; torder[i] = '0;
    end
    nqueued = '0;
    run_slot = NTASK;

    pending_q.push_back(mk(REQ_SCHEDULE, 0, 0, 0, 0));
    pending_q.push_back(mk(REQ_READY, 3, 15, 0, 0));
    pending_q.push_back(mk(REQ_READY, 0, 0, 0, 0));
    pending_q.push_back(mk(REQ_READY, 15, 15, 0, 0));
    pending_q.push_back(mk(REQ_READY, 3, 7, 0, 0));
    pending_q.push_back(mk(REQ_DELAY, 5, 0, 32'd50, 0));
    pending_q.push_back(mk(REQ_DELAY, 6, 0, 32'd50, 0));
    pending_q.push_back(mk(REQ_DELAY, 7, 0, 32'hFFFF_FFFF, 0));
    pending_q.push_back(mk(REQ_DELAY, 5, 0, 32'd1, 0));
    pending_q.push_back(mk(REQ_SCHEDULE, 0, 0, 0, 32'd49));
    pending_q.push_back(mk(REQ_SCHEDULE, 0, 0, 0, 32'd50));
    pending_q.push_back(mk(REQ_SUSPEND, 9, 0, 0, 0));
    pending_q.push_back(mk(REQ_RESUME, 9, 0, 0, 0));
    pending_q.push_back(mk(REQ_SUSPEND, 15, 0, 0, 32'd60));
    pending_q.push_back(mk(REQ_SUSPEND, 15, 0, 0, 32'd60));
    pending_q.push_back(mk(REQ_RESUME, 15, 0, 0, 0));
    pending_q.push_back(mk(REQ_SUSPEND, 0, 0, 0, 0));
    pending_q.push_back(mk(REQ_SUSPEND, 7, 0, 0, 0));
    pending_q.push_back(mk(REQ_SCHEDULE, 0, 0, 0, 32'hFFFF_FFFF));
    pending_q.push_back(mk(REQ_READY, 3, 2, 0, 0));
    pending_q.push_back(mk(REQ_DELAY, 3, 0, 32'd0, 0));
    pending_q.push_back(mk(3'd7, 4, 9, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_q.push_back(mk(3'd5, 0, 0, 0, 0));
    pending_q.push_back(mk(REQ_SCHEDULE, 0, 0, 0, 32'd5));
    for (int i = 0; i < 1330; i++) pending_q.push_back(random_request());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && expect_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d requests sent (%0d schedules), %0d results checked, %0d with a task running",
             n_sent, n_sched, n_checked, n_busy_rsp);
    if (n_errors == 0 && expect_q.size() == 0) begin
      $display("rtos_priority_delay_scheduler test passed");
    end else begin
      $display("%0d errors, %0d results outstanding", n_errors, expect_q.size());
      $display("rtos_priority_delay_scheduler test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rtos_sched_pkg.sv
rtl/core/rtos_sched_cell.sv
rtl/core/rtos_sched_chain.sv
rtl/core/rtos_priority_delay_scheduler.sv
bench/rtos_priority_delay_scheduler_tb.sv
